// ===== rtl/bfbp_pkg.sv =====
// Package for the best-fit buffer pool: pool size, derived widths,
// status and request codes, and the beat types of both channels.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bfbp_pkg;

    localparam int POOL_SLOTS = 64;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

    localparam int SIZE_W     = 32;
    localparam int STAMP_W    = 32;
    localparam int OVER_W     = SIZE_W + 1;
    localparam int CAP_W      = 2 * SIZE_W;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        logic                kind;
        logic [SIZE_W-1:0]   vertex_size;
        logic [SIZE_W-1:0]   index_size;
        logic [5:0]          slot;
    } t_in_beat;

    typedef struct packed {
        logic [5:0]          granted_slot;
        logic                reused;
        t_status             status;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/bfbp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bfbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/best_fit_buffer_pool.sv =====
// Top level of the best-fit buffer pool: sequencer, slot scan pipeline
// and result register. Depends on bfbp_pkg and bfbp_ram.
`timescale 1ns / 1ps
`default_nettype none

// The pool holds up to POOL_SLOTS slots, each with a vertex and an index
// capacity kept in a RAM, plus a free flag per slot held in flip-flops.
// A release beat, like an allocate beat with a zero size, passes through
// the decode and done states of the sequencer: it checks that the slot is
// in the pool and in use, marks it free and stamps it with the running
// release count, and its result beat goes out through the output register.
// An allocate beat with both sizes nonzero scans every slot in the pool,
// one slot per cycle through the single read port of the capacity and
// stamp RAMs. The scan pipeline then drains, the result is decided and
// passes the done state into the output register, and the sequencer
// returns to idle to take the next request; an empty pool skips the scan.
// One shared compare unit picks the free slot that fits both sizes with
// the least total slack, and on equal slack the slot that was released
// longest ago. Without a fit a new slot of exactly the asked sizes is
// appended, or the pool reports full. Input ready is high only while the
// sequencer is idle; a finished result beat waits in the output register,
// so the next request is accepted while the previous result is still
// pending. A result that finds the output register still occupied holds
// the sequencer until that beat is taken.
// No clearing pass is needed after reset: capacities and stamps are only
// read for slots that were appended or released.
module best_fit_buffer_pool
    import bfbp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    // Control state.
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [STAMP_W-1:0]     r_relctr, n_relctr;
    logic [POOL_SLOTS-1:0]  r_free, n_free;
    logic                   r_p1_vld, n_p1_vld;
    logic                   r_p2_vld, n_p2_vld;
    logic                   r_found, n_found;
    logic                   r_out_valid, n_out_valid;

    // Payload state.
    t_in_beat               r_req, n_req;
    logic [SLOT_W-1:0]      r_scan_idx, n_scan_idx;
    logic [SLOT_W-1:0]      r_p1_idx, n_p1_idx;
    logic                   r_p2_fit, n_p2_fit;
    logic [OVER_W-1:0]      r_p2_over, n_p2_over;
    logic [STAMP_W-1:0]     r_p2_age, n_p2_age;
    logic [SLOT_W-1:0]      r_p2_idx, n_p2_idx;
    logic [SLOT_W-1:0]      r_best_idx, n_best_idx;
    logic [OVER_W-1:0]      r_best_over, n_best_over;
    logic [STAMP_W-1:0]     r_best_age, n_best_age;
    t_out_beat              r_res, n_res;
    t_out_beat              r_out, n_out;

    // RAM ports.
    logic                   cap_we;
    logic [SLOT_W-1:0]      cap_waddr;
    logic [CAP_W-1:0]       cap_wdata;
    logic [CAP_W-1:0]       cap_rdata;
    logic                   stamp_we;
    logic [SLOT_W-1:0]      stamp_waddr;
    logic [STAMP_W-1:0]     stamp_wdata;
    logic [STAMP_W-1:0]     stamp_rdata;

    // Scan datapath.
    logic [SIZE_W-1:0]      rd_vcap, rd_icap;
    logic                   a_fit;
    logic [OVER_W-1:0]      a_over;
    logic [STAMP_W-1:0]     a_age;
    logic                   b_take;
    logic [SLOT_W-1:0]      rel_idx;
    logic                   rel_ok;
    logic                   scan_last;
    logic                   pool_full;

    bfbp_ram #(.WIDTH(CAP_W), .DEPTH(POOL_SLOTS)) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (cap_we),
        .i_waddr (cap_waddr),
        .i_wdata (cap_wdata),
        .i_raddr (r_scan_idx),
        .o_rdata (cap_rdata)
    );

    bfbp_ram #(.WIDTH(STAMP_W), .DEPTH(POOL_SLOTS)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (stamp_waddr),
        .i_wdata (stamp_wdata),
        .i_raddr (r_scan_idx),
        .o_rdata (stamp_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Stage A works on the RAM word read in the previous cycle. The free
    // flags do not change during a scan, so they can be sampled here.
    assign rd_vcap = cap_rdata[CAP_W-1:SIZE_W];
    assign rd_icap = cap_rdata[SIZE_W-1:0];
    assign a_fit   = r_free[r_p1_idx] && (rd_vcap >= r_req.vertex_size)
                     && (rd_icap >= r_req.index_size);
    assign a_over  = {1'b0, rd_vcap - r_req.vertex_size}
                   + {1'b0, rd_icap - r_req.index_size};
    assign a_age   = r_relctr - stamp_rdata;

    // Stage B is the shared compare against the best candidate so far.
    assign b_take = r_p2_vld && r_p2_fit &&
                    (!r_found || (r_p2_over < r_best_over) ||
                     ((r_p2_over == r_best_over) && (r_p2_age > r_best_age)));

    // The slot field is range checked against the pool fill, which also
    // keeps it below the pool size.
    assign rel_idx   = SLOT_W'(r_req.slot);
    assign rel_ok    = (32'(r_req.slot) < 32'(r_count)) && !r_free[rel_idx];
    assign scan_last = (CNT_W'(r_scan_idx) == (r_count - CNT_W'(1)));
    assign pool_full = (r_count == CNT_W'(POOL_SLOTS));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_relctr    = r_relctr;
        n_free      = r_free;
        n_found     = r_found;
        n_req       = r_req;
        n_scan_idx  = r_scan_idx;
        n_best_idx  = r_best_idx;
        n_best_over = r_best_over;
        n_best_age  = r_best_age;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        n_p1_vld    = 1'b0;
        n_p1_idx    = r_scan_idx;
        n_p2_vld    = r_p1_vld;
        n_p2_fit    = a_fit;
        n_p2_over   = a_over;
        n_p2_age    = a_age;
        n_p2_idx    = r_p1_idx;

        cap_we      = 1'b0;
        cap_waddr   = SLOT_W'(r_count);
        cap_wdata   = {r_req.vertex_size, r_req.index_size};
        stamp_we    = 1'b0;
        stamp_waddr = rel_idx;
        stamp_wdata = r_relctr;

        if (b_take) begin
            n_found     = 1'b1;
            n_best_idx  = r_p2_idx;
            n_best_over = r_p2_over;
            n_best_age  = r_p2_age;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_found    = 1'b0;
                n_scan_idx = '0;
                if (r_req.kind == KIND_RELEASE) begin
                    n_res = '{granted_slot: r_req.slot, reused: 1'b0, status: ST_BAD};
                    if (rel_ok) begin
                        n_free[rel_idx] = 1'b1;
                        stamp_we        = 1'b1;
                        n_relctr        = r_relctr + STAMP_W'(1);
                        n_res.status    = ST_OK;
                    end
                    n_state = S_DONE;
                end else if ((r_req.vertex_size == '0) || (r_req.index_size == '0)) begin
                    n_res   = '{granted_slot: 6'd0, reused: 1'b0, status: ST_BAD};
                    n_state = S_DONE;
                end else if (r_count == '0) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // The read address is r_scan_idx; its data lands next cycle.
                n_p1_vld   = 1'b1;
                n_scan_idx = r_scan_idx + SLOT_W'(1);
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    if (r_found) begin
                        n_free[r_best_idx] = 1'b0;
                        n_res = '{granted_slot: 6'(r_best_idx), reused: 1'b1,
                                  status: ST_OK};
                    end else if (pool_full) begin
                        n_res = '{granted_slot: 6'd0, reused: 1'b0, status: ST_FULL};
                    end else begin
                        cap_we                 = 1'b1;
                        n_free[SLOT_W'(r_count)] = 1'b0;
                        n_count                = r_count + CNT_W'(1);
                        n_res = '{granted_slot: 6'(r_count), reused: 1'b0,
                                  status: ST_OK};
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_relctr    <= '0;
            r_free      <= '0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_relctr    <= n_relctr;
            r_free      <= n_free;
            r_p1_vld    <= n_p1_vld;
            r_p2_vld    <= n_p2_vld;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_scan_idx  <= n_scan_idx;
        r_p1_idx    <= n_p1_idx;
        r_p2_fit    <= n_p2_fit;
        r_p2_over   <= n_p2_over;
        r_p2_age    <= n_p2_age;
        r_p2_idx    <= n_p2_idx;
        r_best_idx  <= n_best_idx;
        r_best_over <= n_best_over;
        r_best_age  <= n_best_age;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // The pool fill never passes the pool size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= POOL_SLOTS)
        else $error("pool fill count exceeds pool size");

    // The scan pipeline is empty whenever a new request can be taken.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_p1_vld && !r_p2_vld))
        else $error("scan pipeline busy while idle");

    // A reused slot is always reported with an ok status.
    a_reuse_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.reused) |-> (r_out.status == ST_OK))
        else $error("reused slot with failing status");

    // A full pool reports slot zero and no reuse.
    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_FULL)) |->
        (!r_out.reused && (r_out.granted_slot == 6'd0)))
        else $error("pool full beat with stray fields");

    // Accepting a request drops ready in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after accepting a request");

endmodule

`default_nettype wire
